// ===== design/smvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvc_pkg
// Shared types and constants for the share matrix-vector correction unit.
// ----------------------------------------------------------------------------
package smvc_pkg;

   localparam int ROWS_DEFAULT = 256;
   localparam int COLS_DEFAULT = 784;

   localparam int DATA_W      = 64;
   localparam int ROW_W       = 8;
   localparam int COL_W       = 10;
   localparam int FRAC_W      = 6;
   localparam int OPCODE_W    = 2;
   localparam int REQ_TDATA_W = 280;
   localparam int RSP_TDATA_W = 72;

   localparam logic [FRAC_W-1:0] FRAC_BITS_RESET = 6'd13;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD_WEIGHT = 2'd0,
      OP_LOAD_INPUT  = 2'd1,
      OP_COMBINE     = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SHIFT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic write_weight;
      logic write_input;
      logic start;
      logic issue;
      logic shift;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic row_ok;
      logic col_ok;
      logic last_col;
      logic pipe_busy;
   } status_type;

endpackage

// ===== design/smvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvc_ctrl
// Sequencer: decodes requests, walks the columns of a combine and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module smvc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [smvc_pkg::OPCODE_W-1:0] req_opcode,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  smvc_pkg::status_type          status,
   output smvc_pkg::cmd_type             cmd
);

   smvc_pkg::state_type state_ff, state_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                accept;
   logic                out_free;
   smvc_pkg::opcode_type op;

   assign op         = smvc_pkg::opcode_type'(req_opcode);
   assign req_tready = (state_ff == smvc_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign rsp_tvalid = rsp_vld_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smvc_pkg::ST_IDLE: begin
            if (accept && op == smvc_pkg::OP_COMBINE && status.row_ok) begin
               state_in = smvc_pkg::ST_ISSUE;
            end
         end
         smvc_pkg::ST_ISSUE: begin
            if (status.last_col) begin
               state_in = smvc_pkg::ST_DRAIN;
            end
         end
         smvc_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = smvc_pkg::ST_SHIFT;
            end
         end
         smvc_pkg::ST_SHIFT: begin
            state_in = smvc_pkg::ST_OUTPUT;
         end
         smvc_pkg::ST_OUTPUT: begin
            if (out_free) begin
               state_in = smvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         smvc_pkg::ST_IDLE: begin
            cmd.write_weight = accept && op == smvc_pkg::OP_LOAD_WEIGHT
                               && status.row_ok && status.col_ok;
            cmd.write_input  = accept && op == smvc_pkg::OP_LOAD_INPUT && status.col_ok;
            cmd.start        = accept && op == smvc_pkg::OP_COMBINE && status.row_ok;
         end
         smvc_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
         end
         smvc_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         smvc_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         smvc_pkg::ST_OUTPUT: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= smvc_pkg::ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

// ===== design/smvc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvc_datapath
// Share stores, split 64-bit multiply pipeline, accumulator, truncation and
// output register.
// ----------------------------------------------------------------------------
module smvc_datapath #(
   parameter int ROWS = smvc_pkg::ROWS_DEFAULT,
   parameter int COLS = smvc_pkg::COLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smvc_pkg::cmd_type             cmd,
   output smvc_pkg::status_type          status,
   input  logic [smvc_pkg::ROW_W-1:0]    req_row,
   input  logic [smvc_pkg::COL_W-1:0]    req_column,
   input  logic [smvc_pkg::DATA_W-1:0]   req_pub_share,
   input  logic [smvc_pkg::DATA_W-1:0]   req_sec_share,
   input  logic [smvc_pkg::DATA_W-1:0]   req_z_share,
   input  logic [smvc_pkg::DATA_W-1:0]   req_mask,
   input  logic                          csr_we,
   input  logic [smvc_pkg::FRAC_W-1:0]   csr_wdata,
   output logic [smvc_pkg::ROW_W-1:0]    rsp_out_row,
   output logic [smvc_pkg::DATA_W-1:0]   rsp_masked_share
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int DW    = smvc_pkg::DATA_W;
   localparam int HW    = DW / 2;

   logic [DW-1:0] wpub_mem [DEPTH];
   logic [DW-1:0] wsec_mem [DEPTH];
   logic [DW-1:0] xpub_mem [COLS];
   logic [DW-1:0] xsec_mem [COLS];

   logic [AW-1:0] waddr;
   logic [CW-1:0] xaddr;

   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [smvc_pkg::FRAC_W-1:0] frac_ff;
   logic [smvc_pkg::ROW_W-1:0]  row_ff;
   logic [DW-1:0] mask_ff;
   logic [DW-1:0] shifted_ff;
   logic [smvc_pkg::ROW_W-1:0]  out_row_ff;
   logic [DW-1:0] out_share_ff;

   logic          rd_vld_ff, mul_vld_ff, sum_vld_ff, term_vld_ff;
   logic [DW-1:0] rd_wpub_ff, rd_wsec_ff, rd_xpub_ff, rd_xsec_ff;
   logic [DW-1:0] ll_a_ff, ll_b_ff;
   logic [HW-1:0] lh_a_ff, hl_a_ff, lh_b_ff, hl_b_ff;
   logic [DW-1:0] prod_a_ff, prod_b_ff;
   logic [DW-1:0] term_ff;

   assign status.row_ok    = 32'(req_row) < 32'(ROWS);
   assign status.col_ok    = 32'(req_column) < 32'(COLS);
   assign status.last_col  = (col_ff == CW'(COLS - 1));
   assign status.pipe_busy = rd_vld_ff || mul_vld_ff || sum_vld_ff || term_vld_ff;

   assign waddr = AW'(32'(req_row) * 32'(COLS) + 32'(req_column));
   assign xaddr = CW'(req_column);

   // weight stores
   always_ff @(posedge clock) begin
      if (cmd.write_weight) begin
         wpub_mem[waddr] <= req_pub_share;
      end
      rd_wpub_ff <= wpub_mem[wptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_weight) begin
         wsec_mem[waddr] <= req_sec_share;
      end
      rd_wsec_ff <= wsec_mem[wptr_ff];
   end

   // input stores
   always_ff @(posedge clock) begin
      if (cmd.write_input) begin
         xpub_mem[xaddr] <= req_pub_share;
      end
      rd_xpub_ff <= xpub_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_input) begin
         xsec_mem[xaddr] <= req_sec_share;
      end
      rd_xsec_ff <= xsec_mem[col_ff];
   end

   always_comb begin
      col_in  = col_ff;
      wptr_in = wptr_ff;
      if (cmd.start) begin
         col_in  = '0;
         wptr_in = AW'(32'(req_row) * 32'(COLS));
      end else if (cmd.issue) begin
         col_in  = col_ff + CW'(1);
         wptr_in = wptr_ff + AW'(1);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = req_z_share;
      end else if (term_vld_ff) begin
         acc_in = acc_ff - term_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
         sum_vld_ff  <= 1'b0;
         term_vld_ff <= 1'b0;
         frac_ff     <= smvc_pkg::FRAC_BITS_RESET;
      end else begin
         rd_vld_ff   <= cmd.issue;
         mul_vld_ff  <= rd_vld_ff;
         sum_vld_ff  <= mul_vld_ff;
         term_vld_ff <= sum_vld_ff;
         if (csr_we) begin
            frac_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      wptr_ff <= wptr_in;
      acc_ff  <= acc_in;
      if (cmd.start) begin
         row_ff  <= req_row;
         mask_ff <= req_mask;
      end
      // low 64 bits of each product from three 32-bit partial products
      ll_a_ff   <= rd_wpub_ff[HW-1:0] * rd_xsec_ff[HW-1:0];
      lh_a_ff   <= rd_wpub_ff[HW-1:0] * rd_xsec_ff[DW-1:HW];
      hl_a_ff   <= rd_wpub_ff[DW-1:HW] * rd_xsec_ff[HW-1:0];
      ll_b_ff   <= rd_wsec_ff[HW-1:0] * rd_xpub_ff[HW-1:0];
      lh_b_ff   <= rd_wsec_ff[HW-1:0] * rd_xpub_ff[DW-1:HW];
      hl_b_ff   <= rd_wsec_ff[DW-1:HW] * rd_xpub_ff[HW-1:0];
      prod_a_ff <= ll_a_ff + {lh_a_ff + hl_a_ff, {HW{1'b0}}};
      prod_b_ff <= ll_b_ff + {lh_b_ff + hl_b_ff, {HW{1'b0}}};
      term_ff   <= prod_a_ff + prod_b_ff;
      if (cmd.shift) begin
         shifted_ff <= DW'($signed(acc_ff) >>> frac_ff);
      end
      if (cmd.load_out) begin
         out_row_ff   <= row_ff;
         out_share_ff <= shifted_ff + mask_ff;
      end
   end

   assign rsp_out_row      = out_row_ff;
   assign rsp_masked_share = out_share_ff;

endmodule

// ===== design/share_matvec_correction_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// share_matvec_correction_unit
// Secret-shared matrix-vector correction modulo 2^64 with fixed-point
// truncation and masking of one row per combine request.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  req      in         tuser: opcode; tdata: row, column, shares, z, mask
//  rsp      out        tdata: out_row, masked_share
//  csr      in         frac_bits write
//
//  a combine holds the request side until its result is loaded into the
//  output register: one column pair per cycle through the single read port of
//  each share memory, then a drain of the product pipeline, the shift and the output load
//  a finished result waits in the output register; loads are still taken
//  reset clears the sequencer and sets frac_bits to 13; stores are not cleared
// ----------------------------------------------------------------------------
module share_matvec_correction_unit #(
   parameter int ROWS = smvc_pkg::ROWS_DEFAULT,
   parameter int COLS = smvc_pkg::COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row, column, pub share, sec share, z_share, mask, zero pad
   input  logic [smvc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // opcode
   input  logic [smvc_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_row, masked_share
   output logic [smvc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [smvc_pkg::FRAC_W-1:0]         csr_wdata
);

   smvc_pkg::cmd_type    cmd;
   smvc_pkg::status_type status;

   logic [smvc_pkg::ROW_W-1:0]  req_row;
   logic [smvc_pkg::COL_W-1:0]  req_column;
   logic [smvc_pkg::DATA_W-1:0] req_pub_share;
   logic [smvc_pkg::DATA_W-1:0] req_sec_share;
   logic [smvc_pkg::DATA_W-1:0] req_z_share;
   logic [smvc_pkg::DATA_W-1:0] req_mask;
   logic [smvc_pkg::ROW_W-1:0]  rsp_out_row;
   logic [smvc_pkg::DATA_W-1:0] rsp_masked_share;

   assign req_row       = req_tdata[7:0];
   assign req_column    = req_tdata[17:8];
   assign req_pub_share = req_tdata[81:18];
   assign req_sec_share = req_tdata[145:82];
   assign req_z_share   = req_tdata[209:146];
   assign req_mask      = req_tdata[273:210];

   assign rsp_tdata = {rsp_masked_share, rsp_out_row};

   smvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smvc_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_row          (req_row),
      .req_column       (req_column),
      .req_pub_share    (req_pub_share),
      .req_sec_share    (req_sec_share),
      .req_z_share      (req_z_share),
      .req_mask         (req_mask),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_out_row      (rsp_out_row),
      .rsp_masked_share (rsp_masked_share)
   );

   assert property (@(posedge clock) disable iff (reset)
      (cmd.write_weight || cmd.write_input) |-> !status.pipe_busy)
      else $error("store written while products in flight");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_weight, cmd.write_input, cmd.start}))
      else $error("more than one request action in a cycle");

   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_tready && cmd.issue)
      else $error("combine did not begin its column walk");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb_share_matvec_correction_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_share_matvec_correction_unit
// Self-checking bench for the share matrix-vector correction unit. The input
// vector and a few full weight rows are loaded first. A short directed set of
// requests follows, then random phases, each run under its own truncation
// setting. A scoreboard keeps its own copy of the stores and works out every
// masked row share at the moment a combine request is accepted. Both stream
// sides idle at random, and the result side also holds off for one long
// stretch.
// ----------------------------------------------------------------------------

class share_scoreboard;
   localparam int COLS        = smvc_pkg::COLS_DEFAULT;
   localparam int MAX_PRINTED = 40;

   typedef struct {
      logic [smvc_pkg::ROW_W-1:0]  row;
      logic [smvc_pkg::DATA_W-1:0] share;
   } row_share_type;

   bit [smvc_pkg::DATA_W-1:0]   weight_pub[int];
   bit [smvc_pkg::DATA_W-1:0]   weight_sec[int];
   bit [smvc_pkg::DATA_W-1:0]   input_pub[int];
   bit [smvc_pkg::DATA_W-1:0]   input_sec[int];
   logic [smvc_pkg::FRAC_W-1:0] frac_bits;
   row_share_type               expected_shares[$];
   int                          errors;
   int                          combines;
   int                          loads;
   int                          ignored;

   function new();
      frac_bits = smvc_pkg::FRAC_BITS_RESET;
      errors    = 0;
      combines  = 0;
      loads     = 0;
      ignored   = 0;
   endfunction

   task report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   function void note_request(input logic [smvc_pkg::OPCODE_W-1:0] op,
                              input logic [smvc_pkg::ROW_W-1:0] row,
                              input logic [smvc_pkg::COL_W-1:0] col,
                              input logic [smvc_pkg::DATA_W-1:0] pub,
                              input logic [smvc_pkg::DATA_W-1:0] sec,
                              input logic [smvc_pkg::DATA_W-1:0] z,
                              input logic [smvc_pkg::DATA_W-1:0] mask);
      int                          base;
      int                          k;
      logic [smvc_pkg::DATA_W-1:0] acc;
      logic [smvc_pkg::DATA_W-1:0] shifted;
      row_share_type               next_share;
      base = int'(row) * COLS;
      case (op)
         smvc_pkg::OP_LOAD_WEIGHT: begin
            if (col < COLS) begin
               weight_pub[base + int'(col)] = pub;
               weight_sec[base + int'(col)] = sec;
               loads++;
            end else begin
               ignored++;
            end
         end
         smvc_pkg::OP_LOAD_INPUT: begin
            if (col < COLS) begin
               input_pub[int'(col)] = pub;
               input_sec[int'(col)] = sec;
               loads++;
            end else begin
               ignored++;
            end
         end
         smvc_pkg::OP_COMBINE: begin
            acc = z;
            for (k = 0; k < COLS; k++) begin
               acc = acc - weight_pub[base + k] * input_sec[k]
                         - weight_sec[base + k] * input_pub[k];
            end
            // arithmetic shift on the signed view of the corrected share
            shifted          = $signed(acc) >>> frac_bits;
            next_share.row   = row;
            next_share.share = shifted + mask;
            expected_shares.insert(expected_shares.size(), next_share);
            combines++;
         end
         default: begin
            ignored++;
         end
      endcase
   endfunction

   task check_response(input logic [smvc_pkg::ROW_W-1:0] row,
                       input logic [smvc_pkg::DATA_W-1:0] share);
      row_share_type want;
      if (expected_shares.size() == 0) begin
         report_mismatch($sformatf("row %0d share %h with no combine pending", row, share));
      end else begin
         want = expected_shares.pop_front();
         if (row !== want.row) begin
            report_mismatch($sformatf("out_row %0d, expected %0d", row, want.row));
         end
         if (share !== want.share) begin
            report_mismatch($sformatf("row %0d masked_share %h, expected %h",
                                      want.row, share, want.share));
         end
      end
   endtask
endclass

module tb_share_matvec_correction_unit;

   localparam int ROWS          = smvc_pkg::ROWS_DEFAULT;
   localparam int COLS          = smvc_pkg::COLS_DEFAULT;
   localparam int DATA_W        = smvc_pkg::DATA_W;
   localparam int ROW_W         = smvc_pkg::ROW_W;
   localparam int COL_W         = smvc_pkg::COL_W;
   localparam int FRAC_W        = smvc_pkg::FRAC_W;
   localparam int OPCODE_W      = smvc_pkg::OPCODE_W;
   localparam int REQ_TDATA_W   = smvc_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W   = smvc_pkg::RSP_TDATA_W;
   localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 127;
   localparam int HOLD_CYCLES   = 3000;
   localparam int CSR_SETTLE    = 16;
   localparam int END_SETTLE    = 1000;
   localparam longint TIMEOUT_NS = 64'd400_000_000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [OPCODE_W-1:0]    req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we      = 1'b0;
   logic [FRAC_W-1:0]      csr_wdata   = '0;

   share_scoreboard        sb;
   logic                   steady        = 1'b0;
   logic                   hold_response = 1'b0;
   logic [ROW_W-1:0]       filled_rows[3];
   logic [FRAC_W-1:0]      frac_plan[PHASES];

   share_matvec_correction_unit #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [DATA_W-1:0] pick_share();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, {(DATA_W-1){1'b0}}};
         default: return rand64();
      endcase
   endfunction

   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col,
                               input logic [DATA_W-1:0] pub,
                               input logic [DATA_W-1:0] sec,
                               input logic [DATA_W-1:0] z,
                               input logic [DATA_W-1:0] mask);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {6'd0, mask, z, sec, pub, col, row};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, row, col, pub, sec, z, mask);
   endtask

   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      while (sb.expected_shares.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_frac_bits(input logic [FRAC_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      sb.frac_bits = value;
      csr_we    <= 1'b0;
   endtask

   task automatic send_combine(input logic [ROW_W-1:0] row,
                               input logic [DATA_W-1:0] z,
                               input logic [DATA_W-1:0] mask);
      send_request(smvc_pkg::OP_COMBINE, row, COL_W'($urandom), rand64(), rand64(), z,
                   mask);
   endtask

   task automatic send_random_item();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         send_combine(filled_rows[$urandom_range(0, 2)], pick_share(), pick_share());
      end else if (roll < 62) begin
         send_request(smvc_pkg::OP_LOAD_WEIGHT, filled_rows[$urandom_range(0, 2)],
                      COL_W'($urandom_range(0, COLS - 1)), pick_share(), pick_share(),
                      rand64(), rand64());
      end else if (roll < 77) begin
         send_request(smvc_pkg::OP_LOAD_INPUT, ROW_W'($urandom),
                      COL_W'($urandom_range(0, COLS - 1)),
                      pick_share(), pick_share(), rand64(), rand64());
      end else if (roll < 87) begin
         send_request(smvc_pkg::OP_LOAD_WEIGHT, ROW_W'($urandom), COL_W'($urandom),
                      pick_share(), pick_share(), rand64(), rand64());
      end else if (roll < 94) begin
         send_request(smvc_pkg::OP_LOAD_INPUT, ROW_W'($urandom),
                      COL_W'($urandom_range(COLS, 2**COL_W - 1)), rand64(), rand64(),
                      rand64(), rand64());
      end else begin
         send_request(OP_IGNORED, ROW_W'($urandom), COL_W'($urandom), rand64(), rand64(),
                      rand64(), rand64());
      end
   endtask

   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata[ROW_W-1:0], rsp_tdata[ROW_W +: DATA_W]);
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_response) begin
            hold_response = 1'b0;
            stall_left    = HOLD_CYCLES;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         rsp_tready <= !reset && (stall_left == 0);
      end
   end

   initial begin : stimulus
      int c;
      int r;
      int p;
      int i;
      sb             = new();
      filled_rows[0] = '0;
      filled_rows[1] = '1;
      filled_rows[2] = ROW_W'($urandom_range(1, ROWS - 2));
      frac_plan      = '{6'd0, 6'd63, FRAC_W'($urandom_range(2, 61)), 6'd1, 6'd32, 6'd13};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // whole input vector, a zero row and two random rows
      for (c = 0; c < COLS; c++) begin
         send_request(smvc_pkg::OP_LOAD_INPUT, ROW_W'($urandom), COL_W'(c), pick_share(),
                      pick_share(), rand64(), rand64());
      end
      for (c = 0; c < COLS; c++) begin
         send_request(smvc_pkg::OP_LOAD_WEIGHT, filled_rows[0], COL_W'(c), '0, '0,
                      rand64(), rand64());
      end
      for (r = 1; r < 3; r++) begin
         for (c = 0; c < COLS; c++) begin
            send_request(smvc_pkg::OP_LOAD_WEIGHT, filled_rows[r], COL_W'(c), pick_share(),
                         pick_share(), rand64(), rand64());
         end
      end

      // directed requests under the reset truncation
      send_combine(filled_rows[0], '0, '0);
      send_combine(filled_rows[0], '1, '0);
      send_combine(filled_rows[0], {1'b1, {(DATA_W-1){1'b0}}}, '1);
      send_combine(filled_rows[0], {1'b0, {(DATA_W-1){1'b1}}}, 64'd1);
      send_combine(filled_rows[1], rand64(), rand64());
      send_combine(filled_rows[2], rand64(), rand64());
      send_request(OP_IGNORED, filled_rows[0], '0, '1, '1, '1, '1);
      send_request(smvc_pkg::OP_LOAD_INPUT, '0, COL_W'(COLS), '1, '1, '0, '0);
      send_request(smvc_pkg::OP_LOAD_INPUT, '1, '1, rand64(), rand64(), '0, '0);
      send_request(smvc_pkg::OP_LOAD_WEIGHT, filled_rows[1], '1, '1, '1, '0, '0);
      send_request(smvc_pkg::OP_LOAD_WEIGHT, filled_rows[0], COL_W'(COLS - 1), '1, '1,
                   '0, '0);
      send_request(smvc_pkg::OP_LOAD_INPUT, '0, '0, '1, '0, '0, '0);
      send_combine(filled_rows[0], rand64(), rand64());
      send_combine(filled_rows[1], rand64(), '1);

      for (p = 0; p < PHASES; p++) begin
         wait_drained(CSR_SETTLE);
         write_frac_bits(frac_plan[p]);
         steady = (p == 3);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 40) begin
               // result side stalls while combines keep coming
               hold_response = 1'b1;
               for (r = 0; r < 4; r++) begin
                  send_combine(filled_rows[$urandom_range(0, 2)], pick_share(), pick_share());
               end
            end
            send_random_item();
         end
      end
      steady = 1'b0;
      wait_drained(END_SETTLE);

      if (sb.expected_shares.size() != 0) begin
         sb.report_mismatch($sformatf("%0d row shares never arrived",
                                      sb.expected_shares.size()));
      end
      $display("covered %0d requests: %0d combines, %0d loads, %0d ignored",
               sb.combines + sb.loads + sb.ignored, sb.combines, sb.loads, sb.ignored);
      $display("frac_bits used: 13 then %0d %0d %0d %0d %0d %0d, one long result stall",
               frac_plan[0], frac_plan[1], frac_plan[2], frac_plan[3], frac_plan[4],
               frac_plan[5]);
      if (sb.errors == 0) begin
         $display("tb_share_matvec_correction_unit: clean");
      end else begin
         $display("tb_share_matvec_correction_unit: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout: run did not complete");
      $display("tb_share_matvec_correction_unit: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
design/smvc_pkg.sv
design/smvc_ctrl.sv
design/smvc_datapath.sv
design/share_matvec_correction_unit.sv
tb/sv/tb_share_matvec_correction_unit.sv
